>>> hw/rtl/hsrt_pkg.sv
// ----------------------------------------------------------------------------
// hsrt_pkg: shared types and constants of the search result table
// Operation and bound codes, register indexes, stream payload layouts, the
// queued command and the stored entry payload, and the mate score test.
// ----------------------------------------------------------------------------
`default_nettype none

package hsrt_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_PROBE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // bound kinds
   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

   // configuration registers
   localparam int         CSR_IDX_W          = 1;
   localparam int         CSR_DATA_W         = 15;
   localparam logic [0:0] CSR_SEARCH_AGE     = 1'b0;
   localparam logic [0:0] CSR_MATE_THRESHOLD = 1'b1;
   localparam logic [14:0] MATE_THRESHOLD_RST = 15'd31000;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 40;

   // request tdata, first field in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] beta_bound;
      logic [15:0] alpha_bound;
      logic [7:0]  ply_distance;
      logic [1:0]  bound_kind;
      logic [15:0] move_code;
      logic [7:0]  search_depth;
      logic [15:0] new_score;
      logic [63:0] lookup_key;
   } req_data_type;

   // response tdata, first field in the lowest bits
   typedef struct packed {
      logic [4:0]  pad;
      logic        written;
      logic [15:0] result_move;
      logic [15:0] result_score;
      logic        cutoff;
      logic        hit;
   } rsp_data_type;

   // classified request as it waits in the queue
   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [15:0] score;   // already mate adjusted for a store
      logic [7:0]  depth;
      logic [15:0] move;
      logic [1:0]  bound;
      logic [7:0]  ply;
      logic [15:0] alpha;
      logic [15:0] beta;
   } cmd_type;

   // stored entry payload
   typedef struct packed {
      logic [1:0]  bound;
      logic [7:0]  depth;
      logic [7:0]  age;
      logic [15:0] score;
      logic [15:0] move;
   } pay_type;

   localparam int PAY_W = $bits(pay_type);

   // true when the magnitude of a score reaches the mate threshold
   function automatic logic is_mate(input logic [15:0] score, input logic [14:0] thr);
      logic [15:0] mag;
      mag = score[15] ? (~score + 16'd1) : score;
      return mag >= {1'b0, thr};
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hsrt_ram.sv
// ----------------------------------------------------------------------------
// hsrt_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hsrt_fifo.sv
// ----------------------------------------------------------------------------
// hsrt_fifo: short request queue
// Decouples the classifying front end from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hsrt_front.sv
// ----------------------------------------------------------------------------
// hsrt_front: request front end
// Takes requests, applies the mate adjustment of a store score and works out
// the table slot (key modulo the table size), then hands the command on.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrt_front #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      accept_en,
   input  wire logic [14:0]                               mate_threshold,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [hsrt_pkg::REQ_DATA_W-1:0]           req_tdata,
   input  wire logic [1:0]                                req_tuser,
   output logic                                           push_valid,
   input  wire logic                                      push_ready,
   output hsrt_pkg::cmd_type                              push_cmd,
   output logic      [$clog2(TABLE_ENTRIES)-1:0]          push_idx
);

   import hsrt_pkg::*;

   localparam int  IDX_W    = $clog2(TABLE_ENTRIES);
   localparam bit  IS_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   req_data_type req;
   cmd_type      cmd_in;
   cmd_type      cmd_ff;
   logic         hold_valid_ff, hold_valid_in;
   logic         idx_done;
   logic         accept;
   logic [15:0]  ply16;

   assign req   = req_data_type'(req_tdata);
   assign ply16 = {8'd0, req.ply_distance};

   // classify the request and move a mate score away from zero by ply
   always_comb begin
      cmd_in.op    = req_tuser;
      cmd_in.key   = req.lookup_key;
      cmd_in.score = req.new_score;
      cmd_in.depth = req.search_depth;
      cmd_in.move  = req.move_code;
      cmd_in.bound = req.bound_kind;
      cmd_in.ply   = req.ply_distance;
      cmd_in.alpha = req.alpha_bound;
      cmd_in.beta  = req.beta_bound;
      if (is_mate(req.new_score, mate_threshold)) begin
         if (!req.new_score[15] && req.new_score != '0) begin
            cmd_in.score = req.new_score + ply16;
         end else begin
            cmd_in.score = req.new_score - ply16;
         end
      end
   end

   assign push_valid    = hold_valid_ff && idx_done;
   assign req_tready    = accept_en && (!hold_valid_ff || (idx_done && push_ready));
   assign accept        = req_tvalid && req_tready;
   assign push_cmd      = cmd_ff;

   // hold stage
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_valid && push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         // slot is the low key bits
         assign idx_done = 1'b1;
         assign push_idx = cmd_ff.key[IDX_W-1:0];
      end else begin : g_residue
         // key modulo table size, one hex digit of the key per cycle
         localparam int               NIB_STEPS = 16;
         localparam logic [IDX_W+3:0] NW        = (IDX_W + 4)'(TABLE_ENTRIES);

         logic [63:0]      rem_ff;
         logic [IDX_W-1:0] res_ff;
         logic [3:0]       step_ff;
         logic             done_ff;
         logic [IDX_W+3:0] acc;

         always_comb begin
            acc = {res_ff, rem_ff[63:60]};
            for (int k = 3; k >= 0; k--) begin
               if (acc >= (NW << k)) begin
                  acc = acc - (NW << k);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
               step_ff <= '0;
            end else if (accept) begin
               done_ff <= 1'b0;
               step_ff <= '0;
            end else if (hold_valid_ff && !done_ff) begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(NIB_STEPS - 1)) begin
                  done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               rem_ff <= req.lookup_key;
               res_ff <= '0;
            end else if (hold_valid_ff && !done_ff) begin
               rem_ff <= {rem_ff[59:0], 4'd0};
               res_ff <= acc[IDX_W-1:0];
            end
         end

         assign idx_done = done_ff;
         assign push_idx = res_ff;
      end
   endgenerate

endmodule

`default_nettype wire

>>> hw/rtl/hsrt_back.sv
// ----------------------------------------------------------------------------
// hsrt_back: table engine
// Reads the slot, decides replacement or probe cutoff, writes back, and
// sweeps the table clean after reset and on a clear request.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrt_back #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [7:0]                       search_age,
   input  wire logic [14:0]                      mate_threshold,
   input  wire logic                             pop_valid,
   output logic                                  pop_ready,
   input  wire hsrt_pkg::cmd_type                pop_cmd,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] pop_idx,
   output logic                                  init_busy,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output hsrt_pkg::rsp_data_type                rsp_data
);

   import hsrt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] sweep_ff;
   logic             clear_op_ff;
   cmd_type          cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   rsp_data_type     rsp_ff;

   logic             out_free;
   logic             load_rsp;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [63:0]      key_wr, key_rd;
   logic [PAY_W-1:0] pay_wr_bits, pay_rd_bits;
   pay_type          pay_rd, pay_new;
   logic             skip;
   rsp_data_type     exec_rsp;
   logic signed [16:0] ps, alpha_s, beta_s;
   logic [16:0]      ply17;
   logic             key_match, depth_ok, cut;
   logic [15:0]      cut_score;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == ST_EXEC || state_ff == ST_REPLY) && out_free;
   assign pop_ready = state_ff == ST_IDLE;
   assign rd_en     = pop_valid && pop_ready;
   assign init_busy = state_ff == ST_CLEAR && !clear_op_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pay_rd    = pay_type'(pay_rd_bits);

   // replacement: keep a deeper entry of the current age
   assign skip = pay_rd.age == search_age && cmd_ff.depth < pay_rd.depth;

   always_comb begin
      pay_new.bound = cmd_ff.bound;
      pay_new.depth = cmd_ff.depth;
      pay_new.age   = search_age;
      pay_new.score = cmd_ff.score;
      pay_new.move  = cmd_ff.move;
   end

   // probe: move a mate score back toward zero, then check the window
   always_comb begin
      ply17     = {9'd0, cmd_ff.ply};
      ps        = {pay_rd.score[15], pay_rd.score};
      alpha_s   = {cmd_ff.alpha[15], cmd_ff.alpha};
      beta_s    = {cmd_ff.beta[15], cmd_ff.beta};
      key_match = key_rd == cmd_ff.key;
      depth_ok  = pay_rd.depth >= cmd_ff.depth;
      cut       = 1'b0;
      cut_score = '0;
      if (is_mate(pay_rd.score, mate_threshold)) begin
         if (!pay_rd.score[15] && pay_rd.score != '0) begin
            ps = ps - $signed(ply17);
         end else begin
            ps = ps + $signed(ply17);
         end
      end
      if (depth_ok) begin
         case (pay_rd.bound)
            BOUND_EXACT: begin
               cut       = 1'b1;
               cut_score = ps[15:0];
            end
            BOUND_UPPER: begin
               if (ps <= alpha_s) begin
                  cut       = 1'b1;
                  cut_score = cmd_ff.alpha;
               end
            end
            BOUND_LOWER: begin
               if (ps >= beta_s) begin
                  cut       = 1'b1;
                  cut_score = cmd_ff.beta;
               end
            end
            default: begin
               cut = 1'b0;
            end
         endcase
      end
   end

   // build the response of a store or probe
   always_comb begin
      exec_rsp = '0;
      if (cmd_ff.op == OP_STORE) begin
         exec_rsp.written = !skip;
      end else if (key_match) begin
         exec_rsp.hit          = 1'b1;
         exec_rsp.result_move  = pay_rd.move;
         exec_rsp.cutoff       = cut;
         exec_rsp.result_score = cut ? cut_score : 16'd0;
      end
   end

   // write port: sweep zeroes, otherwise a store that wins replacement
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      key_wr      = cmd_ff.key;
      pay_wr_bits = pay_new;
      if (state_ff == ST_CLEAR) begin
         wr_en       = 1'b1;
         wr_addr     = sweep_ff;
         key_wr      = '0;
         pay_wr_bits = '0;
      end else if (state_ff == ST_EXEC && out_free && cmd_ff.op == OP_STORE && !skip) begin
         wr_en = 1'b1;
      end
   end

   hsrt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wr),
      .rd_en   (rd_en),
      .rd_addr (pop_idx),
      .rd_data (key_rd)
   );

   hsrt_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_ENTRIES)) u_pay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pay_wr_bits),
      .rd_en   (rd_en),
      .rd_addr (pop_idx),
      .rd_data (pay_rd_bits)
   );

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clear_op_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new response when there is room, else drop a taken one
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= (state_ff == ST_EXEC) ? exec_rsp : rsp_data_type'('0);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (sweep_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= clear_op_ff ? ST_REPLY : ST_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + IDX_W'(1);
               end
            end
            ST_IDLE: begin
               if (pop_valid) begin
                  cmd_ff <= pop_cmd;
                  idx_ff <= pop_idx;
                  case (pop_cmd.op)
                     OP_STORE: state_ff <= ST_EXEC;
                     OP_PROBE: state_ff <= ST_EXEC;
                     OP_CLEAR: begin
                        clear_op_ff <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     default: state_ff <= ST_REPLY;
                  endcase
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hashed_search_result_table_core.sv
// ----------------------------------------------------------------------------
// hashed_search_result_table_core: depth-preferred transposition table
// Direct-mapped store/probe/clear table of search results with mate scoring.
// ----------------------------------------------------------------------------
// After reset the table is swept to zero, one entry per cycle, and
// req_tready stays low during that sweep (register writes are taken). Every
// request gives exactly one response, in order. A front end takes one request
// per cycle while the queue has room when TABLE_ENTRIES is a power of two
// (slot = low key bits); for other sizes it works out the key residue one hex
// digit per cycle. A two-entry queue feeds the table engine, which takes one
// command at a time: a store or probe as a registered RAM read, then decide
// and write back, an unknown operation as a bare reply, and a clear by
// zeroing the whole table through the single write port.
// Registers: index 0 search_age, index 1 mate_threshold; write them only
// while no request is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_search_result_table_core #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // lookup_key, new_score, search_depth, move_code, bound_kind,
   // ply_distance, alpha_bound, beta_bound, zero pad
   input  wire logic [hsrt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  wire logic [1:0]                           req_tuser,
   // response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // hit, cutoff, result_score, result_move, written, zero pad
   output logic      [hsrt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [hsrt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hsrt_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   import hsrt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CMD_W  = $bits(cmd_type);
   localparam int Q_W    = CMD_W + IDX_W;

   logic [7:0]       search_age_ff;
   logic [14:0]      mate_threshold_ff;
   logic             init_busy;
   logic             push_valid, push_ready;
   cmd_type          push_cmd, pop_cmd;
   logic [IDX_W-1:0] push_idx, pop_idx;
   logic             pop_valid, pop_ready;
   logic [Q_W-1:0]   pop_data;
   rsp_data_type     rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         search_age_ff     <= '0;
         mate_threshold_ff <= MATE_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEARCH_AGE:     search_age_ff     <= csr_wr_data[7:0];
            CSR_MATE_THRESHOLD: mate_threshold_ff <= csr_wr_data[14:0];
            default: begin
               search_age_ff <= search_age_ff;
            end
         endcase
      end
   end

   hsrt_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept_en      (!init_busy),
      .mate_threshold (mate_threshold_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd),
      .push_idx       (push_idx)
   );

   hsrt_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_idx, push_cmd}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_cmd = cmd_type'(pop_data[CMD_W-1:0]);
   assign pop_idx = pop_data[CMD_W +: IDX_W];

   hsrt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .search_age     (search_age_ff),
      .mate_threshold (mate_threshold_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_cmd        (pop_cmd),
      .pop_idx        (pop_idx),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp_data)
   );

   assign rsp_tdata = rsp_data;

   // no request enters while the table is being swept after reset
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !req_tready)
      else $error("request accepted during initial sweep");

   // a store never reports a probe hit
   a_hit_written: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data.hit && rsp_data.written))
      else $error("response marks both hit and written");

   // a cutoff only comes from a hit
   a_cut_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.cutoff |-> rsp_data.hit)
      else $error("cutoff without hit");

   // no cutoff gives a zero score
   a_score_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data.cutoff |-> rsp_data.result_score == 16'd0)
      else $error("score without cutoff");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the hashed search result table core
// Drives store, probe, clear and unknown requests over the request stream,
// predicts every response from a private copy of the table and registers,
// and compares each response field by field. A short table of directed
// requests comes first, then random phases under several register settings
// and several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import hsrt_pkg::*;

   localparam int ENTRIES     = 4096;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RAND_ITEMS  = 72;
   localparam int POOL_N      = 16;
   localparam int DIR_N       = 23;

   // codes outside the defined sets
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [1:0] BOUND_BAD  = 2'd3;

   // one directed request, with a typed-in response where pinned is set
   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [15:0] score;
      logic [7:0]  depth;
      logic [15:0] move;
      logic [1:0]  bound;
      logic [7:0]  ply;
      logic [15:0] alpha;
      logic [15:0] beta;
      logic        pinned;
      logic        hit;
      logic        cut;
      logic [15:0] res;
      logic [15:0] mv;
      logic        wr;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIR_N] = '{
      // empty slot at key 0 hits and cuts off with score 0
      '{OP_PROBE, 64'h0, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b1, 1'b1, 16'h0, 16'h0, 1'b0},
      // key mismatch on an empty slot
      '{OP_PROBE, 64'h1, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // top mate score plus top ply wraps on store
      '{OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF, 8'd255, 16'hFFFF, BOUND_LOWER,
        8'd255, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 8'd255, 16'h0, BOUND_EXACT,
        8'd255, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // shallower store in the same age is skipped
      '{OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 8'd10, 16'h1111, BOUND_EXACT,
        8'd0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // lowest mate score minus top ply wraps on store
      '{OP_STORE, 64'h8000_0000_0000_0000, 16'h8000, 8'd0, 16'h0, BOUND_UPPER,
        8'd255, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'h8000_0000_0000_0000, 16'h0, 8'd0, 16'h0, BOUND_EXACT,
        8'd255, 16'h7FFF, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{OP_PROBE, 64'h0, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // plain exact entry, probed with enough and too little depth
      '{OP_STORE, 64'h123, 16'd100, 8'd5, 16'h1234, BOUND_EXACT, 8'd3,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'h123, 16'h0, 8'd5, 16'h0, BOUND_EXACT, 8'd3,
        16'h0, 16'h0, 1'b1, 1'b1, 1'b1, 16'd100, 16'h1234, 1'b0},
      '{OP_PROBE, 64'h123, 16'h0, 8'd6, 16'h0, BOUND_EXACT, 8'd3,
        16'h0, 16'h0, 1'b1, 1'b1, 1'b0, 16'h0, 16'h1234, 1'b0},
      // other key on the same slot: shallower skipped, equal depth replaces
      '{OP_STORE, 64'h1123, 16'hFFCE, 8'd4, 16'h4321, BOUND_LOWER, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{OP_STORE, 64'h1123, 16'd31000, 8'd5, 16'hABCD, BOUND_LOWER, 8'd7,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'h1123, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd7,
        16'h0, 16'd30000, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{OP_PROBE, 64'h1123, 16'h0, 8'd5, 16'h0, BOUND_EXACT, 8'd7,
        16'h0, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // unknown operation with every field at ones
      '{OP_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF, BOUND_BAD,
        8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // unknown bound kind never cuts off
      '{OP_STORE, 64'h77, 16'h0, 8'd1, 16'h5555, BOUND_BAD, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'h77, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      // clear, then the old key misses and key 0 hits shallow
      '{OP_CLEAR, 64'h0, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{OP_PROBE, 64'h1123, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{OP_PROBE, 64'h0, 16'h0, 8'd1, 16'h0, BOUND_EXACT, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0},
      // negative mate at the threshold, upper bound at alpha
      '{OP_STORE, 64'hFFF, 16'h86E8, 8'd0, 16'h8000, BOUND_UPPER, 8'd0,
        16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1},
      '{OP_PROBE, 64'hFFF, 16'h0, 8'd0, 16'h0, BOUND_EXACT, 8'd0,
        16'h86E8, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0}
   };

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic [1:0]              req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index   = '0;
   logic [CSR_DATA_W-1:0]   csr_wr_data = '0;

   // private copy of the table and the registers
   bit [63:0]      tab_key [ENTRIES];
   bit [PAY_W-1:0] tab_pay [ENTRIES];
   logic [7:0]     cur_age    = 8'd0;
   logic [14:0]    mate_limit = MATE_THRESHOLD_RST;

   rsp_data_type reply_queue [$];
   int           error_count   = 0;
   int           cycle_count   = 0;
   int           send_idle_pct = 34;
   int           rsp_idle_pct  = 88;

   hashed_search_result_table_core #(
      .TABLE_ENTRIES (ENTRIES)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // stall the response side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic bit mate_score(input int s);
      return ((s < 0) ? -s : s) >= int'(mate_limit);
   endfunction

   // apply one request to the private table and return its response
   function automatic rsp_data_type predict_reply(input logic [1:0] op,
                                                  input req_data_type rq);
      rsp_data_type r;
      pay_type      p;
      int           slot;
      int           s;
      int           ply;
      int           alpha;
      int           beta;
      bit           cut;
      int           res;
      r     = '0;
      slot  = int'(rq.lookup_key % ENTRIES);
      p     = pay_type'(tab_pay[slot]);
      ply   = int'(rq.ply_distance);
      alpha = $signed(rq.alpha_bound);
      beta  = $signed(rq.beta_bound);
      cut   = 1'b0;
      res   = 0;
      case (op)
         OP_STORE: begin
            if (!(p.age == cur_age && rq.search_depth < p.depth)) begin
               s = $signed(rq.new_score);
               if (mate_score(s)) s = (s > 0) ? s + ply : s - ply;
               tab_key[slot] = rq.lookup_key;
               p.bound = rq.bound_kind;
               p.depth = rq.search_depth;
               p.age   = cur_age;
               p.score = s[15:0];
               p.move  = rq.move_code;
               tab_pay[slot] = p;
               r.written = 1'b1;
            end
         end
         OP_PROBE: begin
            if (tab_key[slot] == rq.lookup_key) begin
               r.hit         = 1'b1;
               r.result_move = p.move;
               s = $signed(p.score);
               if (mate_score(s)) s = (s > 0) ? s - ply : s + ply;
               if (p.depth >= rq.search_depth) begin
                  if (p.bound == BOUND_EXACT) begin
                     cut = 1'b1;
                     res = s;
                  end else if (p.bound == BOUND_UPPER && s <= alpha) begin
                     cut = 1'b1;
                     res = alpha;
                  end else if (p.bound == BOUND_LOWER && s >= beta) begin
                     cut = 1'b1;
                     res = beta;
                  end
               end
               if (cut) begin
                  r.cutoff       = 1'b1;
                  r.result_score = res[15:0];
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) begin
               tab_key[i] = '0;
               tab_pay[i] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // check each response against the oldest prediction
   always @(posedge clock) begin
      rsp_data_type want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (reply_queue.size() == 0) begin
            $error("response with no request outstanding: %0h", rsp_tdata);
            error_count++;
         end else begin
            want = reply_queue.pop_front();
            compare_field("hit", 16'(want.hit), 16'(got.hit));
            compare_field("cutoff", 16'(want.cutoff), 16'(got.cutoff));
            compare_field("result_score", want.result_score, got.result_score);
            compare_field("result_move", want.result_move, got.result_move);
            compare_field("written", 16'(want.written), 16'(got.written));
         end
      end
   end

   // offer one request, with random gaps, and predict it once taken
   task automatic send_request(input logic [1:0] op, input req_data_type rq,
                               input bit pinned, input rsp_data_type pinned_reply);
      rsp_data_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      r = predict_reply(op, rq);
      reply_queue.push_back(pinned ? pinned_reply : r);
   endtask

   // hold requests until every response is back
   task automatic drain_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_SEARCH_AGE) cur_age = data[7:0];
      else mate_limit = data[14:0];
   endtask

   initial begin
      stim_row_type row;
      req_data_type rq;
      rsp_data_type pr;
      logic [1:0]   op;
      logic [63:0]  key_pool [POOL_N];
      logic [63:0]  wide;
      pay_type      pe;
      int           pick;
      int           sv;
      int           av;
      int           bv;
      logic [7:0]   age_set;
      logic [14:0]  thr_set;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase <= 6; phase++) begin
         // stall pattern: sender light first, then receiver light, then none
         if (phase <= 2) begin
            send_idle_pct = 34;
            rsp_idle_pct  = 88;
         end else if (phase <= 4) begin
            send_idle_pct = 88;
            rsp_idle_pct  = 34;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end

         if (phase == 0) begin
            // directed table under the reset register values
            for (int i = 0; i < DIR_N; i++) begin
               row = DIRECTED[i];
               rq  = '{pad: '0, beta_bound: row.beta, alpha_bound: row.alpha,
                       ply_distance: row.ply, bound_kind: row.bound,
                       move_code: row.move, search_depth: row.depth,
                       new_score: row.score, lookup_key: row.key};
               pr  = '{pad: '0, written: row.wr, result_move: row.mv,
                       result_score: row.res, cutoff: row.cut, hit: row.hit};
               send_request(row.op, rq, row.pinned, pr);
            end
            continue;
         end

         // let the engine go idle, then move to the next register setting
         drain_replies();
         repeat (ENTRIES + 16) @(posedge clock);
         case (phase)
            1: begin age_set = 8'd1;   thr_set = 15'd32767; end
            2: begin age_set = 8'd255; thr_set = 15'd0;     end
            3: begin age_set = 8'd0;   thr_set = MATE_THRESHOLD_RST; end
            4: begin
               age_set = 8'($urandom_range(0, 255));
               thr_set = 15'($urandom_range(0, 32767));
            end
            5: begin age_set = 8'd1;   thr_set = 15'd100;   end
            default: begin
               age_set = 8'($urandom_range(0, 255));
               thr_set = 15'(29000 + $urandom_range(0, 3767));
            end
         endcase
         write_csr(CSR_SEARCH_AGE, CSR_DATA_W'(age_set));
         write_csr(CSR_MATE_THRESHOLD, thr_set);

         // keys for this phase, some sharing a slot with the one before
         for (int i = 0; i < POOL_N; i++) begin
            wide = {$urandom(), $urandom()};
            if (i > 0 && $urandom_range(3) == 0) key_pool[i] = {wide[63:12], key_pool[i-1][11:0]};
            else key_pool[i] = wide;
         end

         for (int n = 0; n < RAND_ITEMS; n++) begin
            // now and then wait for the table to empty its queue
            if ($urandom_range(49) == 0) drain_replies();

            rq = '{pad: '0, beta_bound: 16'($urandom()), alpha_bound: 16'($urandom()),
                   ply_distance: 8'($urandom()), bound_kind: 2'($urandom_range(0, 2)),
                   move_code: 16'($urandom()), search_depth: 8'($urandom_range(0, 15)),
                   new_score: 16'($urandom()), lookup_key: key_pool[$urandom_range(0, POOL_N-1)]};
            pick = $urandom_range(99);
            if (pick < 2) op = OP_CLEAR;
            else if (pick < 5) op = OP_UNKNOWN;
            else if (pick < 47) op = OP_STORE;
            else op = OP_PROBE;

            pick = $urandom_range(99);
            if (pick < 10) rq.lookup_key = {$urandom(), $urandom()};
            else if (pick < 14) rq.lookup_key = 64'h0;
            if ($urandom_range(9) == 0) rq.search_depth = 8'($urandom_range(0, 255));
            if ($urandom_range(4) != 0) rq.ply_distance = 8'($urandom_range(0, 20));
            if ($urandom_range(19) == 0) rq.bound_kind = BOUND_BAD;

            // scores: near the mate threshold, at the ends, small or anything
            case ($urandom_range(0, 5))
               0: begin
                  sv = int'(mate_limit) + int'($urandom_range(0, 4)) - 2;
                  if ($urandom_range(1) == 1) sv = -sv;
                  rq.new_score = sv[15:0];
               end
               1: begin
                  pick = $urandom_range(0, 2);
                  rq.new_score = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'h0;
               end
               2: begin
                  sv = int'($urandom_range(0, 2000)) - 1000;
                  rq.new_score = sv[15:0];
               end
               default: ;
            endcase

            // probe windows mostly around the stored score
            if (op == OP_PROBE && $urandom_range(4) != 0) begin
               pe = pay_type'(tab_pay[int'(rq.lookup_key % ENTRIES)]);
               av = int'($signed(pe.score)) + int'($urandom_range(0, 40)) - 20;
               bv = av + int'($urandom_range(0, 40));
               rq.alpha_bound = av[15:0];
               rq.beta_bound  = bv[15:0];
            end

            send_request(op, rq, 1'b0, '0);
         end
      end

      // wait out the last responses
      drain_replies();
      repeat (20) @(posedge clock);
      if (reply_queue.size() != 0) begin
         $error("%0d responses never arrived", reply_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> hashed_search_result_table_core.f
hw/rtl/hsrt_pkg.sv
hw/rtl/hsrt_ram.sv
hw/rtl/hsrt_fifo.sv
hw/rtl/hsrt_front.sv
hw/rtl/hsrt_back.sv
hw/rtl/hashed_search_result_table_core.sv
sim/tb_top.sv
